FILE: hw/rtl/bibpm_pkg.sv
// ----------------------------------------------------------------------------
// bibpm_pkg: shared types and constants for the beat interval bpm averager
// Holds register indexes, widths, the microcode word layout and the program.
// ----------------------------------------------------------------------------
package bibpm_pkg;

  // ring of kept rates
  localparam int RING_DEPTH = 4;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = 8 + $clog2(RING_DEPTH + 1);
  localparam logic [SUM_W-1:0] RING_DEPTH_SUM = SUM_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0] RING_LAST      = IDX_W'(RING_DEPTH - 1);

  // field widths
  localparam int IR_W    = 18;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 8;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FINGER_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LOW_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_HIGH_LIMIT  = 2'd2;

  localparam logic [IR_W-1:0]   FINGER_THRESHOLD_RST = 18'd10000;
  localparam logic [RATE_W-1:0] RATE_LOW_LIMIT_RST   = 8'd30;
  localparam logic [RATE_W-1:0] RATE_HIGH_LIMIT_RST  = 8'd200;

  // divider: 60000 over the beat interval, one quotient bit per step
  localparam int DIVIDEND_W = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST      = DIV_CNT_W'(DIVIDEND_W - 1);
  localparam logic [RATE_W-1:0]     RATE_SAT      = 8'd255;

  // microcode layout
  localparam int PC_W   = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 3;

  localparam logic [OP_W-1:0] OP_WAIT    = 4'd0;
  localparam logic [OP_W-1:0] OP_DELTA   = 4'd1;
  localparam logic [OP_W-1:0] OP_DIVINIT = 4'd2;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 4'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 4'd4;
  localparam logic [OP_W-1:0] OP_STORE   = 4'd5;
  localparam logic [OP_W-1:0] OP_SUM     = 4'd6;
  localparam logic [OP_W-1:0] OP_MEAN    = 4'd7;
  localparam logic [OP_W-1:0] OP_SATZ    = 4'd8;
  localparam logic [OP_W-1:0] OP_WRITE   = 4'd9;

  localparam logic [COND_W-1:0] JC_NEVER   = 3'd0;
  localparam logic [COND_W-1:0] JC_NOIN    = 3'd1;
  localparam logic [COND_W-1:0] JC_NOBEAT  = 3'd2;
  localparam logic [COND_W-1:0] JC_ZERO    = 3'd3;
  localparam logic [COND_W-1:0] JC_DIVLOOP = 3'd4;
  localparam logic [COND_W-1:0] JC_REJECT  = 3'd5;
  localparam logic [COND_W-1:0] JC_SUMLOOP = 3'd6;
  localparam logic [COND_W-1:0] JC_BUSY    = 3'd7;

  localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] PC_DELTA   = 4'd1;
  localparam logic [PC_W-1:0] PC_DIVINIT = 4'd2;
  localparam logic [PC_W-1:0] PC_DIVSTEP = 4'd3;
  localparam logic [PC_W-1:0] PC_CHECK   = 4'd4;
  localparam logic [PC_W-1:0] PC_STORE   = 4'd5;
  localparam logic [PC_W-1:0] PC_SUM     = 4'd6;
  localparam logic [PC_W-1:0] PC_MEAN    = 4'd7;
  localparam logic [PC_W-1:0] PC_SATZ    = 4'd8;
  localparam logic [PC_W-1:0] PC_WRITE   = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic              ret;     // fall through to the wait step
    logic              always_jmp;
  } ucode_t;

  function automatic ucode_t micro_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_WAIT, cond: JC_NOIN, target: PC_WAIT, ret: 1'b0, always_jmp: 1'b0};
    unique case (pc)
      PC_WAIT:    w = '{OP_WAIT,    JC_NOIN,    PC_WAIT,    1'b0, 1'b0};
      PC_DELTA:   w = '{OP_DELTA,   JC_NOBEAT,  PC_WRITE,   1'b0, 1'b0};
      PC_DIVINIT: w = '{OP_DIVINIT, JC_ZERO,    PC_SATZ,    1'b0, 1'b0};
      PC_DIVSTEP: w = '{OP_DIVSTEP, JC_DIVLOOP, PC_DIVSTEP, 1'b0, 1'b0};
      PC_CHECK:   w = '{OP_CHECK,   JC_REJECT,  PC_WRITE,   1'b0, 1'b0};
      PC_STORE:   w = '{OP_STORE,   JC_NEVER,   PC_WAIT,    1'b0, 1'b0};
      PC_SUM:     w = '{OP_SUM,     JC_SUMLOOP, PC_SUM,     1'b0, 1'b0};
      PC_MEAN:    w = '{OP_MEAN,    JC_NEVER,   PC_WRITE,   1'b0, 1'b1};
      PC_SATZ:    w = '{OP_SATZ,    JC_NEVER,   PC_WAIT,    1'b0, 1'b0};
      PC_WRITE:   w = '{OP_WRITE,   JC_BUSY,    PC_WRITE,   1'b1, 1'b0};
      default:    w = '{OP_WAIT,    JC_NEVER,   PC_WAIT,    1'b1, 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/beat_interval_bpm_averager_core.sv
// ----------------------------------------------------------------------------
// beat_interval_bpm_averager_core: heart rate from beat intervals, 4-deep mean
// Microcoded sequencer: a small program steps a divider, ring and averager.
// ----------------------------------------------------------------------------
// sequence: without a beat a request goes to the write step; a zero interval
//   saturates, a rejected beat skips the ring, a kept one runs the divider
//   (16 steps) and the ring sum (4 steps); no new request is taken until the
//   result is written, bound by the one-bit-per-step restoring divider and ring sum
// reset: synchronous active-low rst_n clears the program counter, handshakes,
//   ring, held average and previous beat time, and loads register defaults
module beat_interval_bpm_averager_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // ir_level[17:0], time_ms[49:18], zero fill
  input  logic        in_tuser,   // beat_seen
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // average_rate[7:0], instant_rate[15:8]
  output logic [1:0]  out_tuser,  // rate_accepted[0], no_finger[1]
  input  logic        cfg_we,
  input  logic [bibpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bibpm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int IR_W   = bibpm_pkg::IR_W;
  localparam int TIME_W = bibpm_pkg::TIME_W;
  localparam int RATE_W = bibpm_pkg::RATE_W;
  localparam int DVD_W  = bibpm_pkg::DIVIDEND_W;
  localparam int IDX_W  = bibpm_pkg::IDX_W;
  localparam int SUM_W  = bibpm_pkg::SUM_W;

  // configuration
  logic [IR_W-1:0]   finger_thr_r;
  logic [RATE_W-1:0] low_lim_r;
  logic [RATE_W-1:0] high_lim_r;

  // sequencer
  logic [bibpm_pkg::PC_W-1:0] pc_r, pc_nxt;
  bibpm_pkg::ucode_t uw;
  logic cond_hit;

  // datapath
  logic              beat_r;
  logic              nofinger_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] prev_time_r;
  logic [TIME_W-1:0] delta_r;
  logic [TIME_W-1:0] rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [bibpm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [RATE_W-1:0] ring_r [bibpm_pkg::RING_DEPTH];
  logic [IDX_W-1:0]  slot_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SUM_W-1:0]  acc_r;
  logic [RATE_W-1:0] held_r;
  logic [RATE_W-1:0] instant_r;
  logic              accepted_r;

  // output register
  logic              out_valid_r;
  logic [RATE_W-1:0] out_avg_r;
  logic [RATE_W-1:0] out_inst_r;
  logic              out_acc_r;
  logic              out_nof_r;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   trial_diff;
  logic              trial_ge;
  logic              above, below, busy;
  logic [SUM_W-1:0]  mean_full;

  assign uw = bibpm_pkg::micro_rom(pc_r);

  assign in_tready  = (uw.op == bibpm_pkg::OP_WAIT);
  assign busy       = out_valid_r && !out_tready;

  assign trial      = {rem_r, quo_r[DVD_W-1]};
  assign trial_diff = trial - {1'b0, delta_r};
  assign trial_ge   = !trial_diff[TIME_W];

  // true rate above low: quotient above, or equal with a fraction left over
  assign above = (quo_r > DVD_W'(low_lim_r)) ||
                 ((quo_r == DVD_W'(low_lim_r)) && (rem_r != '0));
  assign below = quo_r < DVD_W'(high_lim_r);

  assign mean_full = acc_r / bibpm_pkg::RING_DEPTH_SUM;

  always_comb begin
    unique case (uw.cond)
      bibpm_pkg::JC_NEVER:   cond_hit = 1'b0;
      bibpm_pkg::JC_NOIN:    cond_hit = !in_tvalid;
      bibpm_pkg::JC_NOBEAT:  cond_hit = !beat_r;
      bibpm_pkg::JC_ZERO:    cond_hit = (delta_r == '0);
      bibpm_pkg::JC_DIVLOOP: cond_hit = (cnt_r != bibpm_pkg::DIV_LAST);
      bibpm_pkg::JC_REJECT:  cond_hit = !(above && below);
      bibpm_pkg::JC_SUMLOOP: cond_hit = (idx_r != bibpm_pkg::RING_LAST);
      bibpm_pkg::JC_BUSY:    cond_hit = busy;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cond_hit || uw.always_jmp) begin
      pc_nxt = uw.target;
    end else if (uw.ret) begin
      pc_nxt = bibpm_pkg::PC_WAIT;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // control and state that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= bibpm_pkg::PC_WAIT;
      finger_thr_r <= bibpm_pkg::FINGER_THRESHOLD_RST;
      low_lim_r    <= bibpm_pkg::RATE_LOW_LIMIT_RST;
      high_lim_r   <= bibpm_pkg::RATE_HIGH_LIMIT_RST;
      prev_time_r  <= '0;
      slot_r       <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < bibpm_pkg::RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      pc_r <= pc_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          bibpm_pkg::REG_FINGER_THRESHOLD: finger_thr_r <= cfg_wdata[IR_W-1:0];
          bibpm_pkg::REG_RATE_LOW_LIMIT:   low_lim_r    <= cfg_wdata[RATE_W-1:0];
          bibpm_pkg::REG_RATE_HIGH_LIMIT:  high_lim_r   <= cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end

      // the write step reloads the output register itself
      if (out_valid_r && out_tready && (uw.op != bibpm_pkg::OP_WRITE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (uw.op)
        bibpm_pkg::OP_WAIT: begin
          if (in_tvalid && (in_tdata[IR_W-1:0] < finger_thr_r)) begin
            held_r <= '0;
          end
        end
        bibpm_pkg::OP_DELTA: begin
          if (beat_r) begin
            prev_time_r <= time_r;
          end
        end
        bibpm_pkg::OP_STORE: begin
          ring_r[slot_r] <= quo_r[RATE_W-1:0];
          slot_r <= (slot_r == bibpm_pkg::RING_LAST) ? '0 : slot_r + 1'b1;
        end
        bibpm_pkg::OP_MEAN: begin
          held_r <= mean_full[RATE_W-1:0];
        end
        bibpm_pkg::OP_WRITE: begin
          if (!busy) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (uw.op)
      bibpm_pkg::OP_WAIT: begin
        if (in_tvalid) begin
          beat_r     <= in_tuser;
          nofinger_r <= (in_tdata[IR_W-1:0] < finger_thr_r);
          time_r     <= in_tdata[IR_W +: TIME_W];
          instant_r  <= '0;
          accepted_r <= 1'b0;
        end
      end
      bibpm_pkg::OP_DELTA: begin
        delta_r <= time_r - prev_time_r;
      end
      bibpm_pkg::OP_DIVINIT: begin
        rem_r <= '0;
        quo_r <= bibpm_pkg::MS_PER_MINUTE;
        cnt_r <= '0;
      end
      bibpm_pkg::OP_DIVSTEP: begin
        // restoring step: dividend bits shift out as quotient bits shift in
        rem_r <= trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], trial_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      bibpm_pkg::OP_CHECK: begin
        instant_r <= (quo_r > DVD_W'(bibpm_pkg::RATE_SAT)) ?
                     bibpm_pkg::RATE_SAT : quo_r[RATE_W-1:0];
      end
      bibpm_pkg::OP_STORE: begin
        accepted_r <= 1'b1;
        acc_r      <= '0;
        idx_r      <= '0;
      end
      bibpm_pkg::OP_SUM: begin
        acc_r <= acc_r + SUM_W'(ring_r[idx_r]);
        idx_r <= idx_r + 1'b1;
      end
      bibpm_pkg::OP_SATZ: begin
        instant_r <= bibpm_pkg::RATE_SAT;
      end
      bibpm_pkg::OP_WRITE: begin
        if (!busy) begin
          out_avg_r  <= held_r;
          out_inst_r <= instant_r;
          out_acc_r  <= accepted_r;
          out_nof_r  <= nofinger_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_inst_r, out_avg_r};
  assign out_tuser  = {out_nof_r, out_acc_r};

endmodule

FILE: tb/sv/beat_interval_bpm_averager_core_tb.sv
// ----------------------------------------------------------------------------
// beat_interval_bpm_averager_core_tb: self-checking bench for the bpm averager
// Sends samples in random bursts against a stalling receiver. A scoreboard
// predicts each result from the beat intervals and checks every output field.
// ----------------------------------------------------------------------------
module beat_interval_bpm_averager_core_tb;
  import bibpm_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 32;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PHASE_ITEMS     = 240;
  localparam int PHASES          = 8;
  localparam int REPORT_MAX      = 10;
  localparam logic [IR_W-1:0] IR_MAX = '1;

  typedef struct packed {
    logic [RATE_W-1:0] average_rate;
    logic [RATE_W-1:0] instant_rate;
    logic              rate_accepted;
    logic              no_finger;
  } rate_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

  class bpm_scoreboard;
    logic [IR_W-1:0]   finger_thr;
    logic [RATE_W-1:0] low_lim;
    logic [RATE_W-1:0] high_lim;
    logic [TIME_W-1:0] prev_beat_ms;
    logic [RATE_W-1:0] ring [RING_DEPTH];
    logic [IDX_W-1:0]  slot;
    logic [RATE_W-1:0] avg;
    rate_result_t      expected_rates[$];
    int                mismatches;

    function new();
      finger_thr   = FINGER_THRESHOLD_RST;
      low_lim      = RATE_LOW_LIMIT_RST;
      high_lim     = RATE_HIGH_LIMIT_RST;
      prev_beat_ms = '0;
      foreach (ring[i]) ring[i] = '0;
      slot       = '0;
      avg        = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FINGER_THRESHOLD: finger_thr = val[IR_W-1:0];
        REG_RATE_LOW_LIMIT:   low_lim    = val[RATE_W-1:0];
        REG_RATE_HIGH_LIMIT:  high_lim   = val[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction

    // predicts the result of one accepted sample and queues it
    function void note_sample(logic [IR_W-1:0] ir, logic beat, logic [TIME_W-1:0] t_ms);
      rate_result_t      res;
      logic [TIME_W-1:0] delta;
      logic [TIME_W-1:0] quo;
      logic [TIME_W-1:0] rem;
      int unsigned       sum;
      res = '0;
      res.no_finger = (ir < finger_thr);
      if (res.no_finger) avg = '0;
      if (beat) begin
        delta = t_ms - prev_beat_ms;
        prev_beat_ms = t_ms;
        if (delta == '0) begin
          // infinite rate: saturated and never kept
          res.instant_rate = RATE_SAT;
        end else begin
          quo = TIME_W'(MS_PER_MINUTE) / delta;
          rem = TIME_W'(MS_PER_MINUTE) % delta;
          res.instant_rate = (quo > 32'd255) ? RATE_SAT : quo[RATE_W-1:0];
          if (((quo > low_lim) || (quo == low_lim && rem != '0)) && quo < high_lim) begin
            ring[slot] = quo[RATE_W-1:0];
            slot = (slot == RING_LAST) ? '0 : slot + 1'b1;
            sum = 0;
            foreach (ring[i]) sum += ring[i];
            avg = RATE_W'(sum / RING_DEPTH);
            res.rate_accepted = 1'b1;
          end
        end
      end
      res.average_rate = avg;
      expected_rates.push_back(res);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_result(rate_result_t got);
      rate_result_t want;
      if (expected_rates.size() == 0) begin
        flag($sformatf("unexpected result: avg %0d inst %0d acc %0b nf %0b",
                       got.average_rate, got.instant_rate, got.rate_accepted,
                       got.no_finger));
        return;
      end
      want = expected_rates.pop_front();
      if (got.average_rate !== want.average_rate)
        flag($sformatf("average_rate mismatch: expected %0d got %0d",
                       want.average_rate, got.average_rate));
      if (got.instant_rate !== want.instant_rate)
        flag($sformatf("instant_rate mismatch: expected %0d got %0d",
                       want.instant_rate, got.instant_rate));
      if (got.rate_accepted !== want.rate_accepted)
        flag($sformatf("rate_accepted mismatch: expected %0b got %0b",
                       want.rate_accepted, got.rate_accepted));
      if (got.no_finger !== want.no_finger)
        flag($sformatf("no_finger mismatch: expected %0b got %0b",
                       want.no_finger, got.no_finger));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [55:0]          in_tdata;   // ir_level[17:0], time_ms[49:18], zero fill
  logic                 in_tuser;   // beat_seen
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // average_rate[7:0], instant_rate[15:8]
  logic [1:0]           out_tuser;  // rate_accepted[0], no_finger[1]
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bpm_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  event          hold_off_ev;
  bit            holding = 1'b0;
  rx_pattern_e   rx_mode = RX_OPEN;
  int unsigned   rx_left = 0;
  int unsigned   rx_phase = 0;
  logic          rx_ready;

  beat_interval_bpm_averager_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("beat_interval_bpm_averager_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata[7:0], out_tdata[15:8], out_tuser[0], out_tuser[1]});
  end

  // receiver: switches between stall patterns, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_pattern_e'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:     rx_ready = 1'b1;
        RX_COIN:     rx_ready = $urandom_range(0, 1);
        RX_SPARSE:   rx_ready = ($urandom_range(0, 7) != 0);
        RX_PERIODIC: rx_ready = ((rx_phase % 7) >= 3);
        default:     rx_ready = 1'b1;
      endcase
      out_tready <= holding ? 1'b0 : rx_ready;
    end
  end

  initial begin
    forever begin
      @(hold_off_ev);
      holding = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  task automatic send_sample(input logic [IR_W-1:0] ir, input logic beat,
                             input logic [TIME_W-1:0] t_ms);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, t_ms, ir};
    in_tuser  <= beat;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(ir, beat, t_ms);
  endtask

  task automatic beat_after(input logic [IR_W-1:0] ir, input logic [TIME_W-1:0] delta);
    send_sample(ir, 1'b1, sb.prev_beat_ms + delta);
  endtask

  task automatic pause_input(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic drain_results(input bit settle);
    pause_input(1);
    while (sb.pending() != 0) @(posedge clk);
    if (settle) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [IR_W-1:0] thr, input logic [RATE_W-1:0] low,
                           input logic [RATE_W-1:0] high);
    drain_results(1'b1);
    write_reg(REG_FINGER_THRESHOLD, CFG_W'(thr));
    write_reg(REG_RATE_LOW_LIMIT, CFG_W'(low));
    write_reg(REG_RATE_HIGH_LIMIT, CFG_W'(high));
  endtask

  // mostly a finger on the sensor, now and then a level under the threshold
  function automatic logic [IR_W-1:0] finger_ir();
    if ($urandom_range(0, 19) == 0 && sb.finger_thr != 0)
      return IR_W'($urandom_range(0, sb.finger_thr - 1));
    return IR_W'($urandom_range(sb.finger_thr, IR_MAX));
  endfunction

  // beat interval, mostly inside the window the limits accept
  function automatic int unsigned pick_interval();
    int unsigned lo;
    int unsigned hi;
    lo = (sb.high_lim == 0) ? 1 : 60000 / sb.high_lim;
    hi = (sb.low_lim == 0) ? 70000 : 60000 / sb.low_lim + 1;
    if (hi <= lo) hi = lo + 20;
    if (hi > lo + 3000 && $urandom_range(0, 1)) hi = lo + 3000;
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 5000);
    return $urandom_range(lo, hi);
  endfunction

  // interval right at one of the two rate limits, off by at most one
  function automatic logic [TIME_W-1:0] limit_interval();
    int unsigned base;
    if ($urandom_range(0, 1))
      base = (sb.low_lim == 0) ? 60001 : 60000 / sb.low_lim;
    else
      base = (sb.high_lim == 0) ? 1 : 60000 / sb.high_lim;
    return base + $urandom_range(0, 2) - 1;
  endfunction

  task automatic run_directed();
    send_sample('0, 1'b0, 32'd0);
    send_sample(IR_MAX, 1'b0, 32'd5);
    send_sample(FINGER_THRESHOLD_RST - 1'b1, 1'b1, 32'd0);  // zero interval, no finger
    send_sample(FINGER_THRESHOLD_RST, 1'b1, 32'd1000);
    beat_after(18'd20000, 32'd1999);   // quotient at low limit, nonzero remainder
    beat_after(18'd20000, 32'd2000);   // exactly the low limit
    beat_after(18'd20000, 32'd300);    // exactly the high limit
    beat_after(18'd20000, 32'd301);
    beat_after(18'd20000, 32'd1);      // quotient far above 255
    beat_after(18'd5, 32'd500);        // no finger, beat still kept
    beat_after(IR_MAX, 32'd800);       // ring has wrapped, overwrites slot 0
    send_sample(18'd3, 1'b0, sb.prev_beat_ms + 32'd10);
    send_sample(IR_MAX, 1'b1, 32'hFFFF_FF00);  // huge interval, quotient zero
    send_sample(IR_MAX, 1'b1, 32'h0000_0200);  // timestamp wraps
    beat_after(IR_MAX, 32'd0);
    send_sample(IR_MAX, 1'b1, '1);
    repeat (6) send_sample(IR_W'($urandom), 1'b0, $urandom);
  endtask

  task automatic run_random(input int count, input bit with_hold_off);
    int unsigned       to_beat;
    int unsigned       cur_iv;
    int unsigned       step;
    int unsigned       burst_left;
    int unsigned       kind;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] t_ms;
    logic [IR_W-1:0]   ir;
    logic              beat;
    clock_ms   = $urandom;
    cur_iv     = pick_interval();
    to_beat    = cur_iv;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        pause_input($urandom_range(1, 30));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      if (n == count / 2) drain_results(1'b0);
      if (with_hold_off && n == 40) -> hold_off_ev;
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        // regular pulse train: a few samples between beats
        step = $urandom_range(1, cur_iv / 3 + 1);
        if (step >= to_beat) begin
          clock_ms += to_beat;
          beat    = 1'b1;
          cur_iv  = pick_interval();
          to_beat = cur_iv;
        end else begin
          clock_ms += step;
          to_beat -= step;
          beat     = 1'b0;
        end
        t_ms = clock_ms;
        ir   = finger_ir();
      end else if (kind < 86) begin
        ir   = IR_W'($urandom);
        beat = $urandom_range(0, 1);
        t_ms = $urandom;
      end else if (kind < 92) begin
        ir   = finger_ir();
        beat = 1'b1;
        t_ms = sb.prev_beat_ms;
      end else begin
        ir       = finger_ir();
        beat     = 1'b1;
        t_ms     = sb.prev_beat_ms + limit_interval();
        clock_ms = t_ms;
        cur_iv   = pick_interval();
        to_beat  = cur_iv;
      end
      send_sample(ir, beat, t_ms);
    end
    pause_input(1);
  endtask

  initial begin
    logic [RATE_W-1:0] low;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure('0, 8'd0, 8'd255);
        1: configure(IR_MAX, 8'd255, 8'd1);
        2: configure(18'd1, 8'd0, 8'd1);
        7: configure(FINGER_THRESHOLD_RST, RATE_LOW_LIMIT_RST, RATE_HIGH_LIMIT_RST);
        default: begin
          low = $urandom_range(0, 150);
          configure(IR_W'($urandom_range(0, 60000)), low,
                    RATE_W'($urandom_range(low + 1, 255)));
        end
      endcase
      run_random(PHASE_ITEMS, ph == 3);
    end

    drain_results(1'b1);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("beat_interval_bpm_averager_core verification clean");
    end else begin
      $display("beat_interval_bpm_averager_core verification failed");
    end
    $finish;
  end

endmodule
